>>> rtl/rzdd_pkg.sv
// Shared types and constants for the rolling z-score deviation detector.
`timescale 1ns / 1ps
`default_nettype none

package rzdd_pkg;

  // Configuration register indexes
  localparam logic CFG_WINDOW_PERIOD = 1'b0;
  localparam logic CFG_Z_THRESHOLD   = 1'b1;

  // Reset values of the configuration registers
  localparam logic [4:0]  PERIOD_RESET    = 5'd20;
  localparam logic [15:0] THRESHOLD_RESET = 16'd8192;

  // Arithmetic constants
  localparam int          DIGIT_BITS = 16;      // multiplier digit per cycle
  localparam int          ROOT_BITS  = 16;      // confidence search bits
  localparam int          LHS_SHIFT  = 24;      // 2^24 scale of the threshold test
  localparam int          TGT_SHIFT  = 52;      // 2^52 scale of the confidence test
  localparam logic [15:0] CONF_ONE   = 16'd32768;

  // Sample beat
  typedef struct packed {
    logic [5:0]  channel_index;
    logic [31:0] mid_price;
    logic [47:0] sample_time;
  } in_beat_t;

  // Result beat
  typedef struct packed {
    logic [5:0]  result_channel;
    logic        direction;
    logic [15:0] confidence;
    logic [47:0] result_time;
  } out_beat_t;

  // Operand pairs of the shared multiplier
  typedef enum logic [2:0] {
    MSEL_XX,   // sample squared
    MSEL_NQ,   // count times sum of squares
    MSEL_SS,   // sum squared
    MSEL_MM,   // deviation squared
    MSEL_VT    // variance term times threshold squared
  } mul_sel_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic     cap;
    logic     upd;
    logic     fetch;
    logic     acc;
    logic     mul_start;
    mul_sel_t mul_sel;
    logic     q_add;
    logic     v_load;
    logic     v_sub;
    logic     mag_load;
    logic     d2_load;
    logic     w_load;
    logic     root_step;
    logic     emit;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic in_range;
    logic short_win;
    logic k_last;
    logic mul_busy;
    logic v_zero;
    logic over;
    logic thr_zero;
    logic root_last;
    logic out_busy;
  } status_t;

endpackage

`default_nettype wire

>>> rtl/rzdd_ctrl.sv
// Controller state machine sequencing one sample through the datapath.
`timescale 1ns / 1ps
`default_nettype none

module rzdd_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             sample_valid,
  output logic                  idle,
  input  wire rzdd_pkg::status_t st,
  output rzdd_pkg::cmd_t        cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_UPD, S_FETCH, S_ACC, S_SQW,
    S_NQ, S_NQW, S_SS, S_SSW, S_VCHK,
    S_MM, S_MMW, S_VT, S_VTW, S_CMP,
    S_ROOT, S_EMIT
  } state_t;

  state_t state, state_next;

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign idle = (state == S_IDLE);

  // Decode commands and next state
  always_comb begin
    cmd        = '0;
    cmd.mul_sel = rzdd_pkg::MSEL_XX;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.cap = sample_valid;
        if (sample_valid && st.in_range) state_next = S_UPD;
      end
      S_UPD: begin
        cmd.upd = 1'b1;
        state_next = st.short_win ? S_IDLE : S_FETCH;
      end
      S_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc       = 1'b1;
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = rzdd_pkg::MSEL_XX;
        state_next    = S_SQW;
      end
      S_SQW: begin
        if (!st.mul_busy) begin
          cmd.q_add  = 1'b1;
          state_next = st.k_last ? S_NQ : S_FETCH;
        end
      end
      S_NQ: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = rzdd_pkg::MSEL_NQ;
        state_next    = S_NQW;
      end
      S_NQW: begin
        if (!st.mul_busy) begin
          cmd.v_load = 1'b1;
          state_next = S_SS;
        end
      end
      S_SS: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = rzdd_pkg::MSEL_SS;
        state_next    = S_SSW;
      end
      S_SSW: begin
        if (!st.mul_busy) begin
          cmd.v_sub  = 1'b1;
          state_next = S_VCHK;
        end
      end
      S_VCHK: begin
        if (st.v_zero) begin
          state_next = S_IDLE;
        end else begin
          cmd.mag_load = 1'b1;
          state_next   = S_MM;
        end
      end
      S_MM: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = rzdd_pkg::MSEL_MM;
        state_next    = S_MMW;
      end
      S_MMW: begin
        if (!st.mul_busy) begin
          cmd.d2_load = 1'b1;
          state_next  = S_VT;
        end
      end
      S_VT: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = rzdd_pkg::MSEL_VT;
        state_next    = S_VTW;
      end
      S_VTW: begin
        if (!st.mul_busy) begin
          cmd.w_load = 1'b1;
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        priority if (!st.over) state_next = S_IDLE;
        else if (st.thr_zero)  state_next = S_EMIT;
        else                   state_next = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        if (st.root_last) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!st.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/rzdd_dpath.sv
// Datapath: window and channel memories, shared multiplier, root search, result register.
`timescale 1ns / 1ps
`default_nettype none

module rzdd_dpath #(
  parameter int CHANNELS   = 64,
  parameter int MAX_WINDOW = 32,
  parameter int PRICE_BITS = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire rzdd_pkg::in_beat_t  sample,
  input  wire logic [4:0]          period,
  input  wire logic [15:0]         thr,
  input  wire rzdd_pkg::cmd_t      cmd,
  output rzdd_pkg::status_t        st,
  output logic                     result_valid,
  input  wire logic                result_ready,
  output rzdd_pkg::out_beat_t      result
);

  localparam int DB   = rzdd_pkg::DIGIT_BITS;
  localparam int PB   = PRICE_BITS;
  localparam int NB   = $clog2(MAX_WINDOW + 1);
  localparam int PSB  = $clog2(MAX_WINDOW);
  localparam int CB   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int AW   = $clog2(CHANNELS * MAX_WINDOW);
  localparam int SB   = PB + NB;
  localparam int QB   = 2 * PB + NB;
  localparam int VB   = 2 * PB + 2 * NB;
  localparam int WB   = VB + 32;
  localparam int AB   = WB + 34;
  localparam int MB0  = (SB > 32) ? SB : 32;
  localparam int MBW  = DB * ((MB0 + DB - 1) / DB);
  localparam int MDIG = MBW / DB;
  localparam int MCB  = $clog2(MDIG) + 1;
  localparam int PW   = VB + MBW;
  localparam int PPW  = VB + DB;
  localparam int STW  = NB + PSB;
  localparam int RB   = rzdd_pkg::ROOT_BITS;
  localparam int KBB  = $clog2(RB);

  // Captured sample
  logic [5:0]      ch_q;
  logic [CB-1:0]   idx_q;
  logic [PB-1:0]   px_q;
  logic [47:0]     stamp_q;

  // Memories
  logic [PB-1:0]   win  [CHANNELS*MAX_WINDOW];
  logic [STW-1:0]  chst [CHANNELS];
  logic [CHANNELS-1:0] chvld;
  logic [STW-1:0]  rd_st;
  logic            rd_vld;
  logic [PB-1:0]   x_rd;

  // Window walk and sums
  logic [NB-1:0]   n_q, k_q;
  logic [PSB-1:0]  pos_q;
  logic [SB-1:0]   s_q, mag_q;
  logic [QB-1:0]   q_q;
  logic [VB-1:0]   v_q, d2_q;
  logic [WB-1:0]   w_q;
  logic            neg_q;

  // Shared multiplier
  logic [VB-1:0]   m_a;
  logic [MBW-1:0]  m_b;
  logic [PW-1:0]   m_p;
  logic [MCB-1:0]  m_cnt;
  logic            m_busy;
  logic [PPW-1:0]  m_pp;
  logic [VB-1:0]   m_a_next;
  logic [MBW-1:0]  m_b_next;
  logic [31:0]     thr2;

  // Root search
  logic [AB-1:0]   wk_q, g_q, p_q, pt, g_sum, tgt;
  logic [RB-1:0]   c_q;
  logic [KBB-1:0]  kb_q;
  logic            take;

  // Update and address logic
  logic [CB+5:0]   ch_ext;
  logic [CB-1:0]   idx_c;
  logic [PB+31:0]  px_ext;
  logic [NB-1:0]   fill_c;
  logic [PSB-1:0]  pos_c, pos_nx;
  logic [9:0]      nw, off;
  logic [AW-1:0]   base, waddr, raddr;
  logic [SB-1:0]   a_c;
  logic [WB:0]     lhs;
  logic [15:0]     conf_c;

  assign ch_ext = {{CB{1'b0}}, sample.channel_index};
  assign idx_c  = ch_ext[CB-1:0];
  assign px_ext = {{PB{1'b0}}, sample.mid_price};

  // Capture the sample and read its channel state
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      ch_q    <= sample.channel_index;
      idx_q   <= idx_c;
      px_q    <= px_ext[PB-1:0];
      stamp_q <= sample.sample_time;
      if (st.in_range) begin
        rd_st <= chst[idx_c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chvld  <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (cmd.cap && st.in_range) rd_vld <= chvld[idx_c];
      if (cmd.upd) chvld[idx_q] <= 1'b1;
    end
  end

  // Work out the new fill count and ring position
  always_comb begin
    fill_c = rd_vld ? rd_st[STW-1:PSB] : '0;
    pos_c  = rd_vld ? rd_st[PSB-1:0] : '0;
    nw     = 10'(fill_c) + 10'd1;
    if (nw > 10'(period) + 10'd1) nw = nw - 10'd1;
    if (nw > 10'(MAX_WINDOW))     nw = 10'(MAX_WINDOW);
    pos_nx = (pos_c == PSB'(MAX_WINDOW - 1)) ? '0 : pos_c + 1'b1;
    off    = (10'(k_q) <= 10'(pos_q)) ? 10'(pos_q) - 10'(k_q)
                                      : 10'(pos_q) + 10'(MAX_WINDOW) - 10'(k_q);
  end

  assign base  = AW'(idx_q) * AW'(MAX_WINDOW);
  assign waddr = base + AW'(pos_c);
  assign raddr = base + AW'(off);

  // Window and channel memories
  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      win[waddr]  <= px_q;
      chst[idx_q] <= {nw[NB-1:0], pos_nx};
    end
    if (cmd.fetch) x_rd <= win[raddr];
  end

  // Walk the window, accumulate sums and form the variance terms
  assign a_c = SB'(n_q) * SB'(px_q);

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      n_q   <= nw[NB-1:0];
      pos_q <= pos_c;
      k_q   <= '0;
      s_q   <= '0;
      q_q   <= '0;
    end
    if (cmd.acc)    s_q <= s_q + SB'(x_rd);
    if (cmd.q_add) begin
      q_q <= q_q + m_p[QB-1:0];
      k_q <= k_q + 1'b1;
    end
    if (cmd.v_load) v_q <= m_p[VB-1:0];
    if (cmd.v_sub)  v_q <= v_q - m_p[VB-1:0];
    if (cmd.mag_load) begin
      neg_q <= (a_c < s_q);
      mag_q <= (a_c < s_q) ? s_q - a_c : a_c - s_q;
    end
    if (cmd.d2_load) d2_q <= m_p[VB-1:0];
    if (cmd.w_load)  w_q  <= m_p[WB-1:0];
  end

  // Select multiplier operands
  assign thr2 = 32'(thr) * 32'(thr);

  always_comb begin
    unique case (cmd.mul_sel)
      rzdd_pkg::MSEL_XX: begin
        m_a_next = VB'(x_rd);
        m_b_next = MBW'(x_rd);
      end
      rzdd_pkg::MSEL_NQ: begin
        m_a_next = VB'(q_q);
        m_b_next = MBW'(n_q);
      end
      rzdd_pkg::MSEL_SS: begin
        m_a_next = VB'(s_q);
        m_b_next = MBW'(s_q);
      end
      rzdd_pkg::MSEL_MM: begin
        m_a_next = VB'(mag_q);
        m_b_next = MBW'(mag_q);
      end
      rzdd_pkg::MSEL_VT: begin
        m_a_next = v_q;
        m_b_next = MBW'(thr2);
      end
      default: begin
        m_a_next = '0;
        m_b_next = '0;
      end
    endcase
  end

  // Multiply one digit a cycle, top digit first
  assign m_pp = PPW'(m_a) * PPW'(m_b[MBW-1 -: DB]);

  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      m_a <= m_a_next;
      m_b <= m_b_next;
      m_p <= '0;
    end else if (m_busy) begin
      m_p <= (m_p << DB) + PW'(m_pp);
      m_b <= m_b << DB;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_busy <= 1'b0;
      m_cnt  <= '0;
    end else if (cmd.mul_start) begin
      m_busy <= 1'b1;
      m_cnt  <= MCB'(MDIG - 1);
    end else if (m_busy) begin
      if (m_cnt == '0) m_busy <= 1'b0;
      else             m_cnt  <= m_cnt - 1'b1;
    end
  end

  // Confidence search: largest c with c^2 * thr^2 * V <= d2 * 2^52
  assign tgt   = AB'({d2_q, {rzdd_pkg::TGT_SHIFT{1'b0}}});
  assign pt    = p_q + g_q + wk_q;
  assign take  = (pt <= tgt);
  assign g_sum = take ? g_q + (wk_q << 1) : g_q;

  always_ff @(posedge clk) begin
    if (cmd.w_load) begin
      wk_q <= AB'(m_p[WB-1:0]) << (2 * (RB - 1));
      g_q  <= '0;
      p_q  <= '0;
      c_q  <= '0;
      kb_q <= KBB'(RB - 1);
    end else if (cmd.root_step) begin
      if (take) begin
        p_q       <= pt;
        c_q[kb_q] <= 1'b1;
      end
      g_q  <= g_sum >> 1;
      wk_q <= wk_q >> 2;
      kb_q <= kb_q - 1'b1;
    end
  end

  // Result register
  assign conf_c = (thr == '0)              ? rzdd_pkg::CONF_ONE :
                  (c_q > rzdd_pkg::CONF_ONE) ? rzdd_pkg::CONF_ONE : c_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.result_channel <= ch_q;
      result.direction      <= ~neg_q;
      result.confidence     <= conf_c;
      result.result_time    <= stamp_q;
    end
  end

  // Status back to the controller
  assign lhs = (WB+1)'({d2_q, {rzdd_pkg::LHS_SHIFT{1'b0}}});

  always_comb begin
    st.in_range  = (int'(sample.channel_index) < CHANNELS);
    st.short_win = (nw < 10'(period));
    st.k_last    = (10'(k_q) + 10'd1 == 10'(n_q));
    st.mul_busy  = m_busy;
    st.v_zero    = (v_q == '0);
    st.over      = (lhs > (WB+1)'(w_q));
    st.thr_zero  = (thr == '0);
    st.root_last = (kb_q == '0);
    st.out_busy  = result_valid && !result_ready;
  end

endmodule

`default_nettype wire

>>> rtl/rolling_zscore_deviation_detector.sv
// Top level: configuration registers, controller and datapath.
//
// Samples arrive on the sample channel (valid/ready); each beat carries a
// channel index, a Q16.16 price and a timestamp. A sample whose channel index
// is CHANNELS or more is taken and dropped. Otherwise it enters the channel's
// ring window and, once the window holds window_period samples, the block
// scores the newest sample and may emit one beat on the result channel.
// One sample is worked at a time: no new beat is taken until the block is
// back in idle. The cost is set by the shared multiplier, which takes one
// 16-bit digit a cycle and squares each window entry. A sample that scores
// nothing returns the block to idle without a confidence search or an emit.
// The result sits in an output register: a stalled receiver holds it there
// while the next sample is taken; that sample waits only if it too emits.
// Configuration writes are registered on cfg_we; write only while idle.
// Reset (synchronous, active high) clears every channel's window count and
// ring position at once and restores the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module rolling_zscore_deviation_detector #(
  parameter int CHANNELS   = 64,
  parameter int MAX_WINDOW = 32,
  parameter int PRICE_BITS = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                sample_valid,
  output logic                     sample_ready,
  input  wire rzdd_pkg::in_beat_t  sample,
  output logic                     result_valid,
  input  wire logic                result_ready,
  output rzdd_pkg::out_beat_t      result,
  input  wire logic                cfg_we,
  input  wire logic                cfg_index,
  input  wire logic [15:0]         cfg_data
);

  logic [4:0]        period;
  logic [15:0]       thr;
  rzdd_pkg::cmd_t    cmd;
  rzdd_pkg::status_t st;

  // Hold configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      period <= rzdd_pkg::PERIOD_RESET;
      thr    <= rzdd_pkg::THRESHOLD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rzdd_pkg::CFG_WINDOW_PERIOD: period <= cfg_data[4:0];
        rzdd_pkg::CFG_Z_THRESHOLD:   thr    <= cfg_data;
        default: ;
      endcase
    end
  end

  rzdd_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .idle         (sample_ready),
    .st           (st),
    .cmd          (cmd)
  );

  rzdd_dpath #(
    .CHANNELS   (CHANNELS),
    .MAX_WINDOW (MAX_WINDOW),
    .PRICE_BITS (PRICE_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .sample       (sample),
    .period       (period),
    .thr          (thr),
    .cmd          (cmd),
    .st           (st),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

`default_nettype wire

>>> rtl/rzdd_checker.sv
// Port-level checker for the deviation detector, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module rzdd_checker #(
  parameter int CHANNELS = 64
) (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                sample_valid,
  input wire logic                sample_ready,
  input wire rzdd_pkg::in_beat_t  sample,
  input wire logic                result_valid,
  input wire logic                result_ready,
  input wire rzdd_pkg::out_beat_t result
);

  // Hold a stalled result beat
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result beat dropped while stalled");

  // Go busy after taking an in-range sample
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready && (int'(sample.channel_index) < CHANNELS)
    |=> !sample_ready)
    else $error("sample channel still ready after an in-range beat");

  // Raise a result only at the end of busy work
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(!sample_ready))
    else $error("result appeared without work in progress");

  // Cap confidence at one
  a_conf_cap: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.confidence <= rzdd_pkg::CONF_ONE)
    else $error("confidence above one");

endmodule

bind rolling_zscore_deviation_detector rzdd_checker #(
  .CHANNELS (CHANNELS)
) u_rzdd_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_ready (sample_ready),
  .sample       (sample),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

`default_nettype wire

>>> sim/rolling_zscore_deviation_detector_tb.sv
// Testbench for the rolling z-score deviation detector: directed and random samples, scoreboarded.
`timescale 1ns / 1ps

module rolling_zscore_deviation_detector_tb;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                sample_valid = 1'b0;
  logic                sample_ready;
  rzdd_pkg::in_beat_t  sample = '0;
  logic                result_valid;
  logic                result_ready = 1'b0;
  rzdd_pkg::out_beat_t result;
  logic                cfg_we = 1'b0;
  logic                cfg_index = rzdd_pkg::CFG_WINDOW_PERIOD;
  logic [15:0]         cfg_data = '0;

  rolling_zscore_deviation_detector dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Own copy of the per-channel windows and registers
  logic [31:0] ring_price [64][32];
  logic [5:0]  ring_fill  [64];
  logic [4:0]  ring_pos   [64];
  logic [4:0]  period_reg = rzdd_pkg::PERIOD_RESET;
  logic [15:0] thresh_reg = rzdd_pkg::THRESHOLD_RESET;

  rzdd_pkg::out_beat_t pending_alerts[$];
  int          mismatches = 0;
  bit          quiet = 1'b0;
  logic [31:0] chan_base [64];

  initial begin
    for (int c = 0; c < 64; c++) begin
      ring_fill[c] = '0;
      ring_pos[c]  = '0;
      chan_base[c] = $urandom;
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Advance the window of one channel and score its newest sample
  function automatic bit score_sample(input rzdd_pkg::in_beat_t s,
                                      output rzdd_pkg::out_beat_t alert);
    logic [5:0]   ch;
    logic [4:0]   pos;
    logic [6:0]   n;
    logic [63:0]  sum, a, mag;
    logic [255:0] sq_sum, x, var_term, d2, lhs, rhs, tgt, trial, m, thr;
    logic [15:0]  lo, hi, mid;
    bit           neg;
    ch = s.channel_index;
    pos = ring_pos[ch];
    ring_price[ch][pos] = s.mid_price;
    ring_pos[ch] = pos + 5'd1;
    n = ring_fill[ch] + 7'd1;
    if (n > period_reg + 7'd1) n = n - 7'd1;
    if (n > 7'd32) n = 7'd32;
    ring_fill[ch] = n[5:0];
    alert = '0;
    if (n < period_reg) return 1'b0;
    sum = '0;
    sq_sum = '0;
    for (int k = 0; k < n; k++) begin
      x = ring_price[ch][5'(pos - k)];
      sum += x[63:0];
      sq_sum += x * x;
    end
    a = 64'(n) * s.mid_price;
    neg = a < sum;
    mag = neg ? sum - a : a - sum;
    var_term = 256'(n) * sq_sum - 256'(sum) * 256'(sum);
    if (var_term == 0) return 1'b0;
    d2 = 256'(mag) * 256'(mag);
    lhs = d2 << rzdd_pkg::LHS_SHIFT;
    thr = 256'(thresh_reg);
    rhs = thr * thr * var_term;
    if (lhs <= rhs) return 1'b0;
    if (thresh_reg == 0) begin
      lo = rzdd_pkg::CONF_ONE;
    end else begin
      tgt = d2 << rzdd_pkg::TGT_SHIFT;
      lo = 0;
      hi = rzdd_pkg::CONF_ONE;
      while (lo < hi) begin
        mid = 16'((32'(lo) + 32'(hi) + 1) / 2);
        m = 256'(mid) * thr;
        trial = m * m * var_term;
        if (trial <= tgt) lo = mid;
        else hi = mid - 16'd1;
      end
    end
    alert.result_channel = ch;
    alert.direction      = !neg;
    alert.confidence     = lo;
    alert.result_time    = s.sample_time;
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Send one sample beat and record what it should produce
  task automatic send_sample(input logic [5:0] ch, input logic [31:0] price,
                             input logic [47:0] stamp);
    rzdd_pkg::in_beat_t  s;
    rzdd_pkg::out_beat_t alert;
    int                  gap;
    s.channel_index = ch;
    s.mid_price     = price;
    s.sample_time   = stamp;
    gap = pick_gap();
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= s;
    do @(posedge clk); while (!sample_ready);
    if (score_sample(s, alert)) pending_alerts.push_back(alert);
  endtask

  // Drop valid and wait out every outstanding result and the working time
  task automatic wait_idle();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (pending_alerts.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_config(input logic idx, input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == rzdd_pkg::CFG_WINDOW_PERIOD) period_reg = value[4:0];
    else thresh_reg = value;
  endtask

  // Take results with random stalls and compare against the oldest expectation
  int stall_left = 0;
  always @(posedge clk) begin
    rzdd_pkg::out_beat_t want;
    if (!rst) begin
      if (result_valid && result_ready) begin
        if (pending_alerts.size() == 0) begin
          report_mismatch("unexpected beat", result.result_time, 0);
        end else begin
          want = pending_alerts.pop_front();
          if (result.result_channel !== want.result_channel)
            report_mismatch("channel", result.result_channel, want.result_channel);
          if (result.direction !== want.direction)
            report_mismatch("direction", result.direction, want.direction);
          if (result.confidence !== want.confidence)
            report_mismatch("confidence", result.confidence, want.confidence);
          if (result.result_time !== want.result_time)
            report_mismatch("time", result.result_time, want.result_time);
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        result_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < 25) begin
        stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(0, 3);
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  function automatic logic [47:0] rand_stamp();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // Defaults after reset: too few samples to score
  task automatic test_reset_defaults();
    send_sample(6'd0, 32'h0001_0000, 48'h0);
    send_sample(6'd0, 32'h0009_0000, rand_stamp());
    send_sample(6'd0, 32'h0000_0001, rand_stamp());
    wait_idle();
  endtask

  // Two-sample windows give |z| of exactly one: on the threshold and just over it
  task automatic test_threshold_edge();
    write_config(rzdd_pkg::CFG_WINDOW_PERIOD, 16'd1);
    write_config(rzdd_pkg::CFG_Z_THRESHOLD, 16'd4096);
    send_sample(6'd5, 32'd100, rand_stamp());
    send_sample(6'd5, 32'd200, rand_stamp());
    wait_idle();
    write_config(rzdd_pkg::CFG_Z_THRESHOLD, 16'd4095);
    send_sample(6'd5, 32'd50, rand_stamp());
    send_sample(6'd5, 32'd50, rand_stamp());
    send_sample(6'd5, 32'd900, rand_stamp());
    wait_idle();
  endtask

  // Zero period keeps a single sample, so nothing can deviate
  task automatic test_zero_period();
    write_config(rzdd_pkg::CFG_WINDOW_PERIOD, 16'd0);
    write_config(rzdd_pkg::CFG_Z_THRESHOLD, 16'd0);
    send_sample(6'd9, 32'd7, rand_stamp());
    send_sample(6'd9, 32'hFFFF_FFFF, rand_stamp());
    wait_idle();
  endtask

  // Zero threshold with extreme prices and stamps: full confidence both ways; then a spike under the largest threshold
  task automatic test_zero_threshold_extremes();
    write_config(rzdd_pkg::CFG_WINDOW_PERIOD, 16'd1);
    send_sample(6'd63, 32'h0, 48'hFFFF_FFFF_FFFF);
    send_sample(6'd63, 32'hFFFF_FFFF, 48'h0);
    send_sample(6'd63, 32'h0, 48'hFFFF_FFFF_FFFF);
    send_sample(6'd63, 32'h0, rand_stamp());
    wait_idle();
    write_config(rzdd_pkg::CFG_Z_THRESHOLD, 16'hFFFF);
    write_config(rzdd_pkg::CFG_WINDOW_PERIOD, 16'd3);
    send_sample(6'd62, 32'd10, rand_stamp());
    send_sample(6'd62, 32'd10, rand_stamp());
    send_sample(6'd62, 32'hFFFF_FFFF, rand_stamp());
    send_sample(6'd62, 32'd10, rand_stamp());
    wait_idle();
  endtask

  // Noisy prices around a level per channel with occasional spikes
  task automatic test_random_windows(input logic [4:0] period, input logic [15:0] thr,
                                     input int count);
    logic [5:0]  chans[4];
    logic [5:0]  ch;
    logic [31:0] price;
    int          r;
    write_config(rzdd_pkg::CFG_WINDOW_PERIOD, 16'(period));
    write_config(rzdd_pkg::CFG_Z_THRESHOLD, thr);
    quiet = ($urandom_range(0, 3) == 0);
    foreach (chans[i]) chans[i] = 6'($urandom);
    for (int i = 0; i < count; i++) begin
      ch = ($urandom_range(0, 19) == 0) ? 6'($urandom) : chans[$urandom_range(0, 3)];
      r = $urandom_range(0, 99);
      if (r < 12) price = $urandom;
      else price = chan_base[ch] + $urandom_range(0, 4095);
      if (r == 99) chan_base[ch] = $urandom;
      send_sample(ch, price, rand_stamp());
    end
    quiet = 1'b0;
    wait_idle();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_threshold_edge();
    test_zero_period();
    test_zero_threshold_extremes();
    test_random_windows(5'd1, 16'd4095, 150);
    test_random_windows(5'd3, 16'd8192, 150);
    test_random_windows(5'd31, 16'd0, 150);
    test_random_windows(5'd2, 16'hFFFF, 100);
    test_random_windows(5'd6, 16'($urandom_range(2000, 12000)), 150);
    test_random_windows(5'd4, 16'd3000, 150);
    if (mismatches == 0 && pending_alerts.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
